// ===== rtl/u8sd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types and constants
// Request structs for both channels and the command record that the front
// passes to the back.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int CpW = 21;

  localparam logic [CpW-1:0] REPLACEMENT_CP = 21'h00FFFD;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_req_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           run_last;
  } out_req_t;

  // pre replacements, then an optional value, then post replacements
  typedef struct packed {
    logic [1:0]     pre;
    logic           has_val;
    logic [CpW-1:0] val;
    logic [1:0]     post;
  } cmd_t;

endpackage

// ===== rtl/u8sd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_front: byte classifier
// Holds the open-sequence state and turns each accepted byte into at most one
// command record describing the results it causes.
// ----------------------------------------------------------------------------
module u8sd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  u8sd_pkg::in_req_t in_data,
  input  logic              accept,
  output u8sd_pkg::cmd_t    cmd,
  output logic              cmd_valid
);

  logic [20:0] pv_r, pv_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [1:0]  taken_r, taken_nxt;

  logic [7:0] b;
  logic       fresh;

  always_comb begin
    b         = in_data.in_byte;
    fresh     = 1'b0;
    pv_nxt    = pv_r;
    need_nxt  = need_r;
    taken_nxt = taken_r;
    cmd       = '0;

    if (need_r != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        pv_nxt    = {pv_r[14:0], b[5:0]};
        need_nxt  = need_r - 2'd1;
        taken_nxt = taken_r + 2'd1;
        if (need_nxt == 2'd0) begin
          cmd.has_val = 1'b1;
          cmd.val     = pv_nxt;
          pv_nxt      = '0;
          taken_nxt   = '0;
        end
      end else begin
        cmd.pre   = taken_r + 2'd1;
        pv_nxt    = '0;
        need_nxt  = '0;
        taken_nxt = '0;
        fresh     = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (b[7] == 1'b0) begin
        cmd.has_val = 1'b1;
        cmd.val     = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        pv_nxt    = {16'd0, b[4:0]};
        need_nxt  = 2'd1;
        taken_nxt = 2'd0;
      end else if (b[7:4] == 4'b1110) begin
        pv_nxt    = {17'd0, b[3:0]};
        need_nxt  = 2'd2;
        taken_nxt = 2'd0;
      end else if (b[7:3] == 5'b11110) begin
        pv_nxt    = {18'd0, b[2:0]};
        need_nxt  = 2'd3;
        taken_nxt = 2'd0;
      end else begin
        cmd.has_val = 1'b1;
        cmd.val     = u8sd_pkg::REPLACEMENT_CP;
      end
    end

    if (in_data.end_of_text && (need_nxt != 2'd0)) begin
      cmd.post  = taken_nxt + 2'd1;
      pv_nxt    = '0;
      need_nxt  = '0;
      taken_nxt = '0;
    end

    cmd_valid = (cmd.pre != 2'd0) || cmd.has_val || (cmd.post != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= '0;
      need_r  <= '0;
      taken_r <= '0;
    end else if (accept) begin
      pv_r    <= pv_nxt;
      need_r  <= need_nxt;
      taken_r <= taken_nxt;
    end
  end

endmodule

// ===== rtl/u8sd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_fifo: command queue
// Two-entry queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module u8sd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  u8sd_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           pop,
  output u8sd_pkg::cmd_t rd_data,
  output logic           empty
);

  u8sd_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/u8sd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_back: result sequencer
// Expands each command into its code points, one request per cycle while pop is high.
// ----------------------------------------------------------------------------
module u8sd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  u8sd_pkg::cmd_t     cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output u8sd_pkg::out_req_t out_data,
  output logic               empty,
  input  logic               pop
);

  logic        busy_r, busy_nxt;
  logic [1:0]  pre_r, pre_nxt;
  logic [1:0]  post_r, post_nxt;
  logic        has_val_r, has_val_nxt;
  logic [20:0] val_r;

  logic [2:0] remaining;
  logic       last_one;
  logic       take;

  always_comb begin
    remaining = {1'b0, pre_r} + {2'b0, has_val_r} + {1'b0, post_r};
    last_one  = (remaining == 3'd1);
    take      = busy_r && pop;
    cmd_pop   = !cmd_empty && (!busy_r || (take && last_one));

    empty               = !busy_r;
    out_data.run_last   = last_one;
    out_data.code_point = (pre_r == 2'd0 && has_val_r) ? val_r
                                                       : u8sd_pkg::REPLACEMENT_CP;

    busy_nxt    = busy_r;
    pre_nxt     = pre_r;
    has_val_nxt = has_val_r;
    post_nxt    = post_r;
    if (take) begin
      if (pre_r != 2'd0) begin
        pre_nxt = pre_r - 2'd1;
      end else if (has_val_r) begin
        has_val_nxt = 1'b0;
      end else begin
        post_nxt = post_r - 2'd1;
      end
      if (last_one) begin
        busy_nxt = 1'b0;
      end
    end
    if (cmd_pop) begin
      busy_nxt    = 1'b1;
      pre_nxt     = cmd.pre;
      has_val_nxt = cmd.has_val;
      post_nxt    = cmd.post;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pre_r     <= '0;
      has_val_r <= 1'b0;
      post_r    <= '0;
    end else begin
      busy_r    <= busy_nxt;
      pre_r     <= pre_nxt;
      has_val_r <= has_val_nxt;
      post_r    <= post_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      val_r <= cmd.val;
    end
  end

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder: streaming UTF-8 to code point decoder
// Path: a byte's command is registered in the command queue and then in the
// sequencer before its first result is on the result ports, when both are idle.
// Throughput: one byte per cycle while full is low; a byte causing n results
// holds the result sequencer until all n are taken, one per cycle while pop is high.
// Reset: synchronous active-low rst_n closes any open sequence, empties the
// command queue and the sequencer.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  u8sd_pkg::in_req_t  in_data,
  output logic               empty,
  input  logic               pop,
  output u8sd_pkg::out_req_t out_data
);

  u8sd_pkg::cmd_t f_cmd, q_cmd;
  logic           f_valid, q_empty, q_pop;
  logic           accept;

  assign accept = push && !full;

  u8sd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .accept    (accept),
    .cmd       (f_cmd),
    .cmd_valid (f_valid)
  );

  u8sd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept && f_valid),
    .wr_data (f_cmd),
    .full    (full),
    .pop     (q_pop),
    .rd_data (q_cmd),
    .empty   (q_empty)
  );

  u8sd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .out_data  (out_data),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
